// ===== hw/rtl/lfurct_pkg.sv =====
// ----------------------------------------------------------------------------
// lfurct_pkg
// Shared types and constants of the LFU request cache table: field widths,
// item mode and status codes, and the control and flag groups that pass
// between the sequencer and the scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lfurct_pkg;

  // Build defaults
  localparam int ENTRIES_DEF    = 128;
  localparam int KEY_BITS_DEF   = 64;
  localparam int COUNT_BITS_DEF = 16;

  // Largest number of entries that can ever be in use
  localparam int MAX_USED = 128;

  // Field widths on the ports
  localparam int MODE_W   = 2;
  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 32;
  localparam int LENGTH_W = 24;
  localparam int INDEX_W  = 7;
  localparam int SLOT_W   = 7;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 8;

  localparam int IN_DATA_W  = 128;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 128;
  localparam int OUT_USER_W = 4;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 8'd128;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_ACCESS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  // Sequencer to scan unit
  typedef struct packed {
    logic start;      // clear the findings for a new access
    logic vld;        // read data of one entry is present
    logic ent_valid;  // valid bit of that entry
  } scan_ctrl_t;

  // Scan unit findings
  typedef struct packed {
    logic hit;
    logic empty_found;
  } scan_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lfurct_ram.sv =====
// ----------------------------------------------------------------------------
// lfurct_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lfurct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lfurct_scan.sv =====
// ----------------------------------------------------------------------------
// lfurct_scan
// Shared compare unit of the cache table. Takes one entry per cycle and
// keeps the first key match, the first empty entry and the valid entry
// with the lowest use count (lowest index on ties).
// ----------------------------------------------------------------------------
`default_nettype none

module lfurct_scan #(
  parameter int AW         = 7,
  parameter int KEY_BITS   = lfurct_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = lfurct_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lfurct_pkg::scan_ctrl_t        ctrl,
  input  wire logic [KEY_BITS-1:0]           q_key,
  input  wire logic [AW-1:0]                 idx,
  input  wire logic [KEY_BITS-1:0]           rd_key,
  input  wire logic [COUNT_BITS-1:0]         rd_cnt,
  input  wire logic [lfurct_pkg::HANDLE_W-1:0] rd_handle,
  input  wire logic [lfurct_pkg::LENGTH_W-1:0] rd_length,
  output lfurct_pkg::scan_flags_t            flags,
  output logic      [AW-1:0]                 hit_idx,
  output logic      [COUNT_BITS-1:0]         hit_cnt,
  output logic      [lfurct_pkg::HANDLE_W-1:0] hit_handle,
  output logic      [lfurct_pkg::LENGTH_W-1:0] hit_length,
  output logic      [AW-1:0]                 empty_idx,
  output logic      [AW-1:0]                 min_idx,
  output logic      [KEY_BITS-1:0]           min_key
);

  logic                  min_set;
  logic [COUNT_BITS-1:0] min_cnt;
  logic                  match;
  logic                  lower;

  // Key compare and count compare on the entry at hand
  assign match = ctrl.ent_valid && (rd_key == q_key);
  assign lower = !min_set || (rd_cnt < min_cnt);

  // Accumulate findings over the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      flags   <= '0;
      min_set <= 1'b0;
    end else if (ctrl.start) begin
      flags   <= '0;
      min_set <= 1'b0;
    end else if (ctrl.vld) begin
      if (match && !flags.hit) begin
        flags.hit  <= 1'b1;
        hit_idx    <= idx;
        hit_cnt    <= rd_cnt;
        hit_handle <= rd_handle;
        hit_length <= rd_length;
      end
      if (!ctrl.ent_valid && !flags.empty_found) begin
        flags.empty_found <= 1'b1;
        empty_idx         <= idx;
      end
      if (ctrl.ent_valid && lower) begin
        min_set <= 1'b1;
        min_cnt <= rd_cnt;
        min_idx <= idx;
        min_key <= rd_key;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lfu_request_cache_table_unit.sv =====
// ----------------------------------------------------------------------------
// lfu_request_cache_table_unit
// Fully associative cache table with least-frequently-used replacement.
// ----------------------------------------------------------------------------
// An access item scans the n entries in use (n = active_entries, 0 taken as
// 1, capped at the built size and at 128) one entry per cycle through a
// single key and count compare unit fed by the key, count, handle and length
// RAMs, then updates one entry. An access passes the scan, drain, update and
// output states before the next accept; a delete, flush or unused mode goes
// straight to output. The scan length, set by the one read port of each RAM,
// dominates. Input is taken only while the sequencer is idle; a finished
// result waits in the output register without holding up the next item. No
// clearing pass after reset: valid bits are flip-flops that gate RAM data.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_request_cache_table_unit #(
  parameter int ENTRIES    = lfurct_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = lfurct_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = lfurct_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration: active_entries
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lfurct_pkg::CFG_W-1:0]      cfg_data,
  // Input items
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // key[63:0], content_handle[95:64], content_length[119:96],
  // entry_index[126:120], zero [127]
  input  wire logic [lfurct_pkg::IN_DATA_W-1:0]  s_tdata,
  // mode[1:0]
  input  wire logic [lfurct_pkg::IN_USER_W-1:0]  s_tuser,
  // Result items
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // slot[6:0], stored_handle[38:7], stored_length[62:39],
  // evicted_key[126:63], zero [127]
  output logic      [lfurct_pkg::OUT_DATA_W-1:0] m_tdata,
  // hit[0], evicted[1], status[3:2]
  output logic      [lfurct_pkg::OUT_USER_W-1:0] m_tuser
);

  localparam int USED = (ENTRIES < lfurct_pkg::MAX_USED) ? ENTRIES : lfurct_pkg::MAX_USED;
  localparam int AW   = (USED > 1) ? $clog2(USED) : 1;
  localparam int CW   = lfurct_pkg::CFG_W;
  localparam int HW   = lfurct_pkg::HANDLE_W;
  localparam int LW   = lfurct_pkg::LENGTH_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_OUTPUT
  } state_t;

  state_t              state;
  logic [CW-1:0]       active;
  logic [CW-1:0]       n_use;
  logic [USED-1:0]     ent_valid;
  logic [CW-1:0]       issue_cnt;

  // Latched item
  logic [KEY_BITS-1:0] q_key;
  logic [HW-1:0]       q_handle;
  logic [LW-1:0]       q_length;

  // Read pipeline beside the RAMs
  logic                p_vld;
  logic [AW-1:0]       p_idx;
  logic                p_valid;

  // Staged result
  logic                                     r_hit;
  logic [lfurct_pkg::SLOT_W-1:0]            r_slot;
  logic [HW-1:0]                            r_handle;
  logic [LW-1:0]                            r_length;
  logic                                     r_evicted;
  logic [lfurct_pkg::KEY_W-1:0]             r_evkey;
  logic [lfurct_pkg::STATUS_W-1:0]          r_status;

  // Input fields
  logic [lfurct_pkg::INDEX_W-1:0] in_idx;
  logic                           in_acc;

  // RAM ports
  logic [AW-1:0]         raddr;
  logic [AW-1:0]         wr_idx;
  logic                  data_we;
  logic                  cnt_we;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [HW-1:0]         rd_handle;
  logic [LW-1:0]         rd_length;

  // Scan unit
  lfurct_pkg::scan_ctrl_t  sc_ctrl;
  lfurct_pkg::scan_flags_t sc_flags;
  logic [AW-1:0]           hit_idx;
  logic [COUNT_BITS-1:0]   hit_cnt;
  logic [HW-1:0]           hit_handle;
  logic [LW-1:0]           hit_length;
  logic [AW-1:0]           empty_idx;
  logic [AW-1:0]           min_idx;
  logic [KEY_BITS-1:0]     min_key;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign in_idx    = s_tdata[126:120];

  // Clamp the number of entries in use
  always_comb begin
    if (active == '0) begin
      n_use = CW'(1);
    end else if (active > CW'(USED)) begin
      n_use = CW'(USED);
    end else begin
      n_use = active;
    end
  end

  // Pick the entry to update and its new count
  always_comb begin
    raddr = issue_cnt[AW-1:0];
    if (sc_flags.hit) begin
      wr_idx = hit_idx;
    end else if (sc_flags.empty_found) begin
      wr_idx = empty_idx;
    end else begin
      wr_idx = min_idx;
    end
    cnt_inc   = (&hit_cnt) ? hit_cnt : hit_cnt + COUNT_BITS'(1);
    cnt_wdata = sc_flags.hit ? cnt_inc : COUNT_BITS'(1);
    cnt_we    = (state == ST_UPDATE);
    data_we   = (state == ST_UPDATE) && !sc_flags.hit;
  end

  assign sc_ctrl.start     = in_acc && (s_tuser == lfurct_pkg::MODE_ACCESS);
  assign sc_ctrl.vld       = p_vld;
  assign sc_ctrl.ent_valid = p_valid;

  lfurct_ram #(.WIDTH(KEY_BITS), .DEPTH(USED)) u_key_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (wr_idx),
    .wdata (q_key),
    .raddr (raddr),
    .rdata (rd_key)
  );

  lfurct_ram #(.WIDTH(HW), .DEPTH(USED)) u_handle_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (wr_idx),
    .wdata (q_handle),
    .raddr (raddr),
    .rdata (rd_handle)
  );

  lfurct_ram #(.WIDTH(LW), .DEPTH(USED)) u_length_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (wr_idx),
    .wdata (q_length),
    .raddr (raddr),
    .rdata (rd_length)
  );

  lfurct_ram #(.WIDTH(COUNT_BITS), .DEPTH(USED)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (wr_idx),
    .wdata (cnt_wdata),
    .raddr (raddr),
    .rdata (rd_cnt)
  );

  lfurct_scan #(.AW(AW), .KEY_BITS(KEY_BITS), .COUNT_BITS(COUNT_BITS)) u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (sc_ctrl),
    .q_key      (q_key),
    .idx        (p_idx),
    .rd_key     (rd_key),
    .rd_cnt     (rd_cnt),
    .rd_handle  (rd_handle),
    .rd_length  (rd_length),
    .flags      (sc_flags),
    .hit_idx    (hit_idx),
    .hit_cnt    (hit_cnt),
    .hit_handle (hit_handle),
    .hit_length (hit_length),
    .empty_idx  (empty_idx),
    .min_idx    (min_idx),
    .min_key    (min_key)
  );

  // Sequencer, valid bits and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      active    <= lfurct_pkg::ACTIVE_RESET;
      ent_valid <= '0;
      issue_cnt <= '0;
      p_vld     <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        active <= cfg_data;
      end
      // Retire an accepted result unless a new one takes its place
      if (m_tvalid && m_tready && (state != ST_OUTPUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            q_key     <= s_tdata[KEY_BITS-1:0];
            q_handle  <= s_tdata[95:64];
            q_length  <= s_tdata[119:96];
            r_hit     <= 1'b0;
            r_slot    <= '0;
            r_handle  <= '0;
            r_length  <= '0;
            r_evicted <= 1'b0;
            r_evkey   <= '0;
            r_status  <= lfurct_pkg::STAT_OK;
            case (s_tuser)
              lfurct_pkg::MODE_ACCESS: begin
                issue_cnt <= '0;
                state     <= ST_SCAN;
              end
              lfurct_pkg::MODE_DELETE: begin
                if (CW'(in_idx) >= n_use) begin
                  r_status <= lfurct_pkg::STAT_RANGE;
                end else if (!ent_valid[in_idx[AW-1:0]]) begin
                  r_status <= lfurct_pkg::STAT_EMPTY;
                end else begin
                  ent_valid[in_idx[AW-1:0]] <= 1'b0;
                end
                state <= ST_OUTPUT;
              end
              lfurct_pkg::MODE_FLUSH: begin
                ent_valid <= '0;
                state     <= ST_OUTPUT;
              end
              default: begin
                state <= ST_OUTPUT;
              end
            endcase
          end
        end
        ST_SCAN: begin
          // Issue one entry read per cycle
          p_vld     <= 1'b1;
          p_idx     <= issue_cnt[AW-1:0];
          p_valid   <= ent_valid[issue_cnt[AW-1:0]];
          issue_cnt <= issue_cnt + CW'(1);
          if (issue_cnt + CW'(1) == n_use) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // Last entry reaches the compare unit
          p_vld <= 1'b0;
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (sc_flags.hit) begin
            r_hit    <= 1'b1;
            r_slot   <= lfurct_pkg::SLOT_W'(hit_idx);
            r_handle <= hit_handle;
            r_length <= hit_length;
          end else begin
            ent_valid[wr_idx] <= 1'b1;
            r_slot            <= lfurct_pkg::SLOT_W'(wr_idx);
            if (!sc_flags.empty_found) begin
              r_evicted <= 1'b1;
              r_evkey   <= lfurct_pkg::KEY_W'(min_key);
            end
          end
          state <= ST_OUTPUT;
        end
        ST_OUTPUT: begin
          // Hand the result to the output register once it is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, r_evkey, r_length, r_handle, r_slot};
            m_tuser  <= {r_status, r_evicted, r_hit};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lfurct_checker.sv =====
// ----------------------------------------------------------------------------
// lfurct_checker
// Port-level checks of the LFU request cache table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lfurct_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [lfurct_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic [lfurct_pkg::OUT_USER_W-1:0] m_tuser
);

  // One item at a time: input closes right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is at work");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // A hit never evicts, and an error status carries no eviction
  a_flags: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[0] || m_tuser[3:2] != lfurct_pkg::STAT_OK)) |-> !m_tuser[1])
    else $error("eviction reported with a hit or a delete status");

  // Without an eviction the evicted key reads zero
  a_evkey: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[1]) |-> (m_tdata[126:63] == '0))
    else $error("evicted key set without an eviction");

endmodule

bind lfu_request_cache_table_unit lfurct_checker u_lfurct_checker (.*);

`default_nettype wire

// ===== bench/lfu_request_cache_table_unit_tb.sv =====
// ----------------------------------------------------------------------------
// LFU request cache table unit testbench
// Drives access, delete, flush and unused-mode items into the cache table
// under several table sizes and idling patterns. A behavioral copy of the
// table predicts every result, and the results are checked field by field
// in arrival order. A long receiver hold-off backs up the table, and a
// heavily hit entry is shown to outlast eviction in a two-entry table.
// ----------------------------------------------------------------------------
module lfu_request_cache_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [lfurct_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [15:0] COUNT_TOP = 16'hFFFF;
  localparam int HOLD_CYCLES = 600;
  localparam int STALL_LIMIT = 4000;
  localparam int HOT_HITS = 6;
  localparam int SEG_ITEMS = 80;

  typedef struct packed {
    logic [lfurct_pkg::MODE_W-1:0]   mode;
    logic [lfurct_pkg::KEY_W-1:0]    key;
    logic [lfurct_pkg::HANDLE_W-1:0] handle;
    logic [lfurct_pkg::LENGTH_W-1:0] length;
    logic [lfurct_pkg::INDEX_W-1:0]  index;
  } req_t;

  typedef struct packed {
    logic                            hit;
    logic [lfurct_pkg::SLOT_W-1:0]   slot;
    logic [lfurct_pkg::HANDLE_W-1:0] handle;
    logic [lfurct_pkg::LENGTH_W-1:0] length;
    logic                            evicted;
    logic [lfurct_pkg::KEY_W-1:0]    ekey;
    logic [lfurct_pkg::STATUS_W-1:0] status;
  } resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [lfurct_pkg::CFG_W-1:0]      cfg_data = '0;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [lfurct_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic [lfurct_pkg::IN_USER_W-1:0]  s_tuser = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [lfurct_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [lfurct_pkg::OUT_USER_W-1:0] m_tuser;

  lfu_request_cache_table_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the table and its size register
  logic [lfurct_pkg::CFG_W-1:0]    active_cfg = lfurct_pkg::ACTIVE_RESET;
  logic                            tbl_vld [lfurct_pkg::MAX_USED];
  logic [lfurct_pkg::KEY_W-1:0]    tbl_key [lfurct_pkg::MAX_USED];
  logic [lfurct_pkg::HANDLE_W-1:0] tbl_handle [lfurct_pkg::MAX_USED];
  logic [lfurct_pkg::LENGTH_W-1:0] tbl_length [lfurct_pkg::MAX_USED];
  logic [15:0]                     tbl_count [lfurct_pkg::MAX_USED];

  req_t  pending_reqs [$];
  resp_t expected_resps [$];
  req_t  bus_req;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;
  int errors = 0;

  int n_items = 0, n_hits = 0, n_misses = 0, n_evicts = 0, n_deletes = 0;
  int n_range = 0, n_empty = 0, n_flushes = 0, n_unused = 0, n_sizes = 0;

  initial begin
    for (int i = 0; i < lfurct_pkg::MAX_USED; i++) begin
      tbl_vld[i] = 1'b0;
      tbl_count[i] = '0;
      tbl_key[i] = '0;
      tbl_handle[i] = '0;
      tbl_length[i] = '0;
    end
  end

  // Entries in use for a size setting: zero means one, cap at the table size
  function automatic int used_entries(input logic [lfurct_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > lfurct_pkg::MAX_USED) return lfurct_pkg::MAX_USED;
    return int'(v);
  endfunction

  // Apply one item to the shadow table and return the result it produces
  function automatic resp_t lfu_table_apply(input req_t r);
    resp_t o;
    int n;
    int pick;
    int i;
    o = '0;
    n = used_entries(active_cfg);
    pick = -1;
    if (r.mode == lfurct_pkg::MODE_ACCESS) begin
      for (i = 0; i < n; i++)
        if (pick < 0 && tbl_vld[i] && tbl_key[i] == r.key) pick = i;
      if (pick >= 0) begin
        // hit: bump the count unless it is pinned at the top
        if (tbl_count[pick] != COUNT_TOP) tbl_count[pick] = tbl_count[pick] + 1'b1;
        o.hit = 1'b1;
        o.slot = lfurct_pkg::SLOT_W'(pick);
        o.handle = tbl_handle[pick];
        o.length = tbl_length[pick];
      end else begin
        for (i = 0; i < n; i++)
          if (pick < 0 && !tbl_vld[i]) pick = i;
        if (pick < 0) begin
          // no free entry: evict the lowest count, lowest index wins ties
          pick = 0;
          for (i = 1; i < n; i++)
            if (tbl_count[i] < tbl_count[pick]) pick = i;
          o.evicted = 1'b1;
          o.ekey = tbl_key[pick];
        end
        tbl_vld[pick] = 1'b1;
        tbl_key[pick] = r.key;
        tbl_handle[pick] = r.handle;
        tbl_length[pick] = r.length;
        tbl_count[pick] = 16'd1;
        o.slot = lfurct_pkg::SLOT_W'(pick);
      end
    end else if (r.mode == lfurct_pkg::MODE_DELETE) begin
      if (r.index >= n) begin
        o.status = lfurct_pkg::STAT_RANGE;
      end else if (!tbl_vld[r.index]) begin
        o.status = lfurct_pkg::STAT_EMPTY;
      end else begin
        tbl_vld[r.index] = 1'b0;
        tbl_count[r.index] = '0;
      end
    end else if (r.mode == lfurct_pkg::MODE_FLUSH) begin
      for (i = 0; i < lfurct_pkg::MAX_USED; i++) begin
        tbl_vld[i] = 1'b0;
        tbl_count[i] = '0;
      end
    end
    return o;
  endfunction

  function automatic void push_req(input logic [lfurct_pkg::MODE_W-1:0] mode,
                                   input logic [lfurct_pkg::KEY_W-1:0] key,
                                   input logic [lfurct_pkg::HANDLE_W-1:0] handle,
                                   input logic [31:0] length,
                                   input logic [lfurct_pkg::INDEX_W-1:0] index);
    req_t r;
    r.mode = mode;
    r.key = key;
    r.handle = handle;
    r.length = length[lfurct_pkg::LENGTH_W-1:0];
    r.index = index;
    pending_reqs.push_back(r);
  endfunction

  // Random traffic: mostly accesses to a small key pool so hits and
  // evictions happen, plus deletes, flushes and stray keys
  task automatic queue_traffic(input int count, input int n);
    logic [lfurct_pkg::KEY_W-1:0] pool [$];
    logic [lfurct_pkg::KEY_W-1:0] key;
    logic [lfurct_pkg::MODE_W-1:0] mode;
    logic [lfurct_pkg::INDEX_W-1:0] idx;
    int pool_n;
    int roll;
    int k;
    pool_n = $urandom_range(2, (n < 20) ? n + 4 : 24);
    for (k = 0; k < pool_n; k++) pool.push_back({$urandom, $urandom});
    for (k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      mode = (roll < 78) ? lfurct_pkg::MODE_ACCESS : (roll < 92) ? lfurct_pkg::MODE_DELETE :
             (roll < 96) ? MODE_UNUSED : lfurct_pkg::MODE_FLUSH;
      key = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_n - 1)]
                                         : {$urandom, $urandom};
      idx = ($urandom_range(0, 99) < 80) ? lfurct_pkg::INDEX_W'($urandom_range(0, n - 1))
                                         : lfurct_pkg::INDEX_W'($urandom_range(0, 127));
      push_req(mode, key, $urandom, $urandom, idx);
    end
  endtask

  // Wait until every queued item has gone in and every result has come out
  task automatic settle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || expected_resps.size() != 0);
  endtask

  task automatic write_active(input logic [lfurct_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    active_cfg = v;
    n_sizes++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: predict on accept, then offer the next pending item or idle
  always @(posedge clk) begin
    resp_t res;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        res = lfu_table_apply(bus_req);
        expected_resps.push_back(res);
        n_items++;
        if (bus_req.mode == lfurct_pkg::MODE_ACCESS) begin
          if (res.hit) n_hits++;
          else n_misses++;
          if (res.evicted) n_evicts++;
        end else if (bus_req.mode == lfurct_pkg::MODE_DELETE) begin
          n_deletes++;
          if (res.status == lfurct_pkg::STAT_RANGE) n_range++;
          if (res.status == lfurct_pkg::STAT_EMPTY) n_empty++;
        end else if (bus_req.mode == lfurct_pkg::MODE_FLUSH) begin
          n_flushes++;
        end else begin
          n_unused++;
        end
      end
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          bus_req = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {1'b0, bus_req.index, bus_req.length, bus_req.handle, bus_req.key};
          s_tuser <= bus_req.mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest prediction, drive ready
  always @(posedge clk) begin
    resp_t got;
    resp_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.slot = m_tdata[6:0];
        got.handle = m_tdata[38:7];
        got.length = m_tdata[62:39];
        got.ekey = m_tdata[126:63];
        got.hit = m_tuser[0];
        got.evicted = m_tuser[1];
        got.status = m_tuser[3:2];
        if (expected_resps.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0h %0h", $time, m_tuser, m_tdata);
          errors++;
        end else begin
          want = expected_resps.pop_front();
          check_field("hit", 64'(want.hit), 64'(got.hit));
          check_field("slot", 64'(want.slot), 64'(got.slot));
          check_field("stored_handle", 64'(want.handle), 64'(got.handle));
          check_field("stored_length", 64'(want.length), 64'(got.length));
          check_field("evicted", 64'(want.evicted), 64'(got.evicted));
          check_field("evicted_key", want.ekey, got.ekey);
          check_field("status", 64'(want.status), 64'(got.status));
        end
      end
      // hold off once for a long stretch so the table backs up
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("lfu_request_cache_table_unit: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [lfurct_pkg::CFG_W-1:0] sizes [7];
    logic [lfurct_pkg::KEY_W-1:0] ka, kb, kc;
    int seg;
    sizes = '{8'd4, 8'd0, 8'd255, 8'd16, 8'd1, 8'd128, 8'd7};
    ka = {$urandom, $urandom};
    kb = {$urandom, $urandom};
    kc = {$urandom, $urandom};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 54;

    // Directed: extremes of the fields at the reset table size
    push_req(lfurct_pkg::MODE_ACCESS, '0, '0, '0, '0);
    push_req(lfurct_pkg::MODE_ACCESS, '1, '1, '1, '1);
    push_req(lfurct_pkg::MODE_ACCESS, '0, '1, '1, '0);
    push_req(lfurct_pkg::MODE_ACCESS, '1, '0, '0, '1);
    push_req(lfurct_pkg::MODE_DELETE, ka, '1, '1, 7'd127);
    push_req(lfurct_pkg::MODE_DELETE, '0, '0, '0, 7'd0);
    push_req(lfurct_pkg::MODE_DELETE, '1, '0, '0, 7'd0);
    push_req(lfurct_pkg::MODE_ACCESS, ka, 32'h89ab_cdef, 24'h12_3456, 7'd5);
    push_req(MODE_UNUSED, '1, '1, '1, '1);
    push_req(lfurct_pkg::MODE_FLUSH, kb, $urandom, $urandom, 7'd3);
    push_req(lfurct_pkg::MODE_ACCESS, '1, 32'h5555_aaaa, 24'haa_5555, '0);
    settle();

    // Directed: two entries, eviction by count and lowest index on ties
    write_active(8'd2);
    push_req(lfurct_pkg::MODE_ACCESS, kb, $urandom, $urandom, '0);
    push_req(lfurct_pkg::MODE_ACCESS, kb, $urandom, $urandom, '0);
    push_req(lfurct_pkg::MODE_ACCESS, kc, $urandom, $urandom, '0);
    push_req(lfurct_pkg::MODE_ACCESS, kc, $urandom, $urandom, '0);
    push_req(lfurct_pkg::MODE_ACCESS, ka, $urandom, $urandom, '0);
    push_req(lfurct_pkg::MODE_DELETE, ka, $urandom, $urandom, 7'd2);
    push_req(lfurct_pkg::MODE_DELETE, ka, $urandom, $urandom, 7'd127);
    push_req(lfurct_pkg::MODE_DELETE, ka, $urandom, $urandom, 7'd1);
    push_req(lfurct_pkg::MODE_ACCESS, kb, $urandom, $urandom, '0);
    settle();

    // Random traffic over several table sizes and idling patterns
    for (seg = 0; seg < 7; seg++) begin
      if (seg == 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 7;
      end
      if (seg == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_active(sizes[seg]);
      queue_traffic(SEG_ITEMS, used_entries(sizes[seg]));
      if (seg == 0) hold_request = 1'b1;
      settle();
    end

    // Build up one hot entry, then show it survives eviction
    write_active(8'd2);
    push_req(lfurct_pkg::MODE_FLUSH, '0, '0, '0, '0);
    push_req(lfurct_pkg::MODE_ACCESS, ka, $urandom, $urandom, '0);
    for (int i = 0; i < HOT_HITS; i++) begin
      push_req(lfurct_pkg::MODE_ACCESS, ka, $urandom, $urandom, '0);
    end
    push_req(lfurct_pkg::MODE_ACCESS, kb, $urandom, $urandom, '0);
    for (int i = 0; i < 3; i++) push_req(lfurct_pkg::MODE_ACCESS, kb, $urandom, $urandom, '0);
    push_req(lfurct_pkg::MODE_ACCESS, kc, $urandom, $urandom, '0);
    push_req(lfurct_pkg::MODE_ACCESS, kb, $urandom, $urandom, '0);
    push_req(lfurct_pkg::MODE_ACCESS, ka, $urandom, $urandom, '0);
    settle();
    repeat (140) @(posedge clk);

    $display("Ran %0d items over %0d size settings: %0d hits, %0d misses, %0d evictions.",
             n_items, n_sizes, n_hits, n_misses, n_evicts);
    $display("Deletes %0d (%0d out of range, %0d already empty), flushes %0d, unused mode %0d.",
             n_deletes, n_range, n_empty, n_flushes, n_unused);
    if (errors == 0) begin
      $display("lfu_request_cache_table_unit: match");
    end else begin
      $display("lfu_request_cache_table_unit: mismatch");
    end
    $finish;
  end

endmodule
